/* src/tbc_pkg.sv */
// tbc_pkg: widths, payload structs and divider stage type for the
// barycentric coordinate pipeline; no dependencies
`timescale 1ns / 1ps
package tbc_pkg;

  // coordinate format
  localparam int CW = 32;
  localparam int FB = 16;

  // datapath widths
  localparam int DFW  = CW + 1;          // coordinate differences
  localparam int PRW  = 2 * DFW;         // difference products
  localparam int NW   = PRW + 1;         // cross product components
  localparam int LOW  = (NW + 1) / 2;    // low half of a split operand
  localparam int HIW  = NW - LOW;        // high half of a split operand
  localparam int PPW  = 2 * (LOW + 1);   // partial products
  localparam int SQW  = 2 * NW;          // full component products
  localparam int DOTW = SQW + 2;         // dot products
  localparam int DW   = DOTW + 1;        // doubled divisor
  localparam int MW   = DOTW + FB + 2;   // scaled and biased dividend

  // configuration
  localparam int TW   = 31;
  localparam int TSQW = 2 * TW;
  localparam int ADW  = 3;
  localparam logic [ADW-3:0] REG_TOL = '0;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic signed [CW-1:0] vert_a_x;
    logic signed [CW-1:0] vert_a_y;
    logic signed [CW-1:0] vert_a_z;
    logic signed [CW-1:0] vert_b_x;
    logic signed [CW-1:0] vert_b_y;
    logic signed [CW-1:0] vert_b_z;
    logic signed [CW-1:0] vert_c_x;
    logic signed [CW-1:0] vert_c_y;
    logic signed [CW-1:0] vert_c_z;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] weight_u;
    logic signed [CW-1:0] weight_v;
    logic signed [CW-1:0] weight_w;
    logic                 degenerate;
  } out_t;

  // one quotient lane of the restoring divider
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [CW-1:0] mlo;
    logic [CW-1:0] quo;
    logic          neg;
    logic          ovf;
  } div_lane_t;

  // divider stage: shared divisor, u and v lanes
  typedef struct packed {
    logic [DW-1:0]        den2;
    logic                 deg;
    div_lane_t [1:0]      lane;
  } div_t;

endpackage

/* src/triangle_barycentric_coords.sv */
// triangle_barycentric_coords: pipelined barycentric weights of a 3D point
// against a triangle in signed Q16.16; depends on tbc_pkg
//
// throughput: one transaction per cycle; busy stays low, the pipeline never stalls
// the 32 restoring divider stages (one quotient bit each) set most of the latency
// reset (synchronous, rst_n low) empties the pipeline and sets the tolerance to 1
`timescale 1ns / 1ps
module triangle_barycentric_coords (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  tbc_pkg::in_t              in_data,
  output logic                      out_strobe,
  output tbc_pkg::out_t             out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [tbc_pkg::ADW-1:0]   paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int CW   = tbc_pkg::CW;
  localparam int FB   = tbc_pkg::FB;
  localparam int DFW  = tbc_pkg::DFW;
  localparam int PRW  = tbc_pkg::PRW;
  localparam int NW   = tbc_pkg::NW;
  localparam int LOW  = tbc_pkg::LOW;
  localparam int HIW  = tbc_pkg::HIW;
  localparam int PPW  = tbc_pkg::PPW;
  localparam int SQW  = tbc_pkg::SQW;
  localparam int DOTW = tbc_pkg::DOTW;
  localparam int DW   = tbc_pkg::DW;
  localparam int MW   = tbc_pkg::MW;
  localparam int TW   = tbc_pkg::TW;
  localparam int TSQW = tbc_pkg::TSQW;
  localparam int NDS  = CW;            // divider stages
  localparam int PRE  = 9;             // stages up to the divider entry
  localparam int NV   = PRE + NDS + 1; // total latency

  // one restoring step on both lanes
  function automatic tbc_pkg::div_t div_step(input tbc_pkg::div_t s);
    tbc_pkg::div_t r;
    logic [DW:0]   r2;
    logic          ge;
    r = s;
    for (int l = 0; l < 2; l++) begin
      r2 = {s.lane[l].rem, s.lane[l].mlo[CW-1]};
      ge = (r2 >= {1'b0, s.den2});
      if (ge) begin
        r2 = r2 - {1'b0, s.den2};
      end
      r.lane[l].rem = r2[DW-1:0];
      r.lane[l].mlo = {s.lane[l].mlo[CW-2:0], 1'b0};
      r.lane[l].quo = {s.lane[l].quo[CW-2:0], ge};
    end
    return r;
  endfunction

  // handshake and valid chain
  logic          accept;
  logic [NV-1:0] vld_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NV-2:0], accept};
    end
  end

  assign out_strobe = vld_r[NV-1];

  // configuration register
  logic [TW-1:0]   tol_r;
  logic [TSQW-1:0] tsq_r;
  logic            cfg_wr;
  logic            cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = (paddr[tbc_pkg::ADW-1:2] == tbc_pkg::REG_TOL);
  assign prdata  = cfg_sel ? {1'b0, tol_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TW'(1);
    end else if (cfg_wr && cfg_sel) begin
      tol_r <= pwdata[TW-1:0];
    end
  end

  // squared tolerance, registered; the user must let it settle while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    tsq_r <= tol_r * tol_r;
  end

  // stage 1: coordinate differences
  logic signed [CW-1:0]  pc [3];
  logic signed [CW-1:0]  ac [3];
  logic signed [CW-1:0]  bc [3];
  logic signed [CW-1:0]  cc [3];
  logic signed [DFW-1:0] df_r [6][3];

  assign pc[0] = in_data.point_x;
  assign pc[1] = in_data.point_y;
  assign pc[2] = in_data.point_z;
  assign ac[0] = in_data.vert_a_x;
  assign ac[1] = in_data.vert_a_y;
  assign ac[2] = in_data.vert_a_z;
  assign bc[0] = in_data.vert_b_x;
  assign bc[1] = in_data.vert_b_y;
  assign bc[2] = in_data.vert_b_z;
  assign cc[0] = in_data.vert_c_x;
  assign cc[1] = in_data.vert_c_y;
  assign cc[2] = in_data.vert_c_z;

  // pairs: (b-a, c-a) for the normal, (b-p, c-p) for u, (p-a, c-a) for v
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      df_r[0][i] <= DFW'(bc[i]) - DFW'(ac[i]);
      df_r[1][i] <= DFW'(cc[i]) - DFW'(ac[i]);
      df_r[2][i] <= DFW'(bc[i]) - DFW'(pc[i]);
      df_r[3][i] <= DFW'(cc[i]) - DFW'(pc[i]);
      df_r[4][i] <= DFW'(pc[i]) - DFW'(ac[i]);
      df_r[5][i] <= DFW'(cc[i]) - DFW'(ac[i]);
    end
  end

  // stages 2 and 3: cross product terms, then components
  logic signed [PRW-1:0] prod_r [3][6];
  logic signed [NW-1:0]  cr_r [9];

  for (genvar g = 0; g < 3; g++) begin : g_cross
    for (genvar i = 0; i < 3; i++) begin : g_comp
      localparam int J = (i + 1) % 3;
      localparam int K = (i + 2) % 3;
      always_ff @(posedge clk) begin
        prod_r[g][2*i]   <= df_r[2*g][J] * df_r[2*g+1][K];
        prod_r[g][2*i+1] <= df_r[2*g][K] * df_r[2*g+1][J];
        cr_r[3*g+i]      <= NW'(prod_r[g][2*i]) - NW'(prod_r[g][2*i+1]);
      end
    end
  end

  // stages 4 and 5: split products for n.n, tu.n and tv.n
  logic signed [PPW-1:0] pp_r [9][4];
  logic signed [SQW-1:0] sq_r [9];

  for (genvar p = 0; p < 9; p++) begin : g_dot
    localparam int Q = p % 3;
    logic signed [HIW-1:0] xh;
    logic signed [HIW-1:0] yh;
    logic signed [LOW:0]   xl;
    logic signed [LOW:0]   yl;
    assign xh = $signed(cr_r[p][NW-1:LOW]);
    assign yh = $signed(cr_r[Q][NW-1:LOW]);
    assign xl = $signed({1'b0, cr_r[p][LOW-1:0]});
    assign yl = $signed({1'b0, cr_r[Q][LOW-1:0]});
    always_ff @(posedge clk) begin
      pp_r[p][0] <= xh * yh;
      pp_r[p][1] <= xh * yl;
      pp_r[p][2] <= xl * yh;
      pp_r[p][3] <= xl * yl;
      sq_r[p]    <= (SQW'(pp_r[p][0]) <<< (2 * LOW))
                  + ((SQW'(pp_r[p][1]) + SQW'(pp_r[p][2])) <<< LOW)
                  + SQW'(pp_r[p][3]);
    end
  end

  // stage 6: dot product sums (den, num u, num v)
  logic signed [DOTW-1:0] dot_r [3];

  always_ff @(posedge clk) begin
    for (int g = 0; g < 3; g++) begin
      dot_r[g] <= DOTW'(sq_r[3*g]) + DOTW'(sq_r[3*g+1]) + DOTW'(sq_r[3*g+2]);
    end
  end

  // stage 7: degenerate test, numerator magnitudes
  logic [DOTW-1:0] thr;
  logic [DOTW-1:0] den7_r;
  logic            deg7_r;
  logic [DOTW-1:0] abs7_r [2];
  logic            neg7_r [2];

  assign thr = DOTW'({tsq_r, {(2 * FB){1'b0}}});

  always_ff @(posedge clk) begin
    den7_r <= dot_r[0];
    deg7_r <= (dot_r[0] == '0) || (DOTW'(dot_r[0]) < thr);
    for (int l = 0; l < 2; l++) begin
      neg7_r[l] <= dot_r[l+1][DOTW-1];
      abs7_r[l] <= dot_r[l+1][DOTW-1] ? DOTW'(-dot_r[l+1]) : DOTW'(dot_r[l+1]);
    end
  end

  // stage 8: dividend with rounding bias, doubled divisor
  logic [MW-1:0] m8_r [2];
  logic [DW-1:0] d8_r;
  logic          deg8_r;
  logic          neg8_r [2];

  always_ff @(posedge clk) begin
    d8_r   <= {den7_r, 1'b0};
    deg8_r <= deg7_r;
    for (int l = 0; l < 2; l++) begin
      neg8_r[l] <= neg7_r[l];
      m8_r[l]   <= (MW'(abs7_r[l]) << (FB + 1)) + MW'(den7_r);
    end
  end

  // stage 9: overflow check and divider entry, then one quotient bit a stage
  tbc_pkg::div_t dv_r [NDS+1];

  always_ff @(posedge clk) begin
    dv_r[0].den2 <= d8_r;
    dv_r[0].deg  <= deg8_r;
    for (int l = 0; l < 2; l++) begin
      dv_r[0].lane[l].rem <= DW'(m8_r[l][MW-1:CW]);
      dv_r[0].lane[l].mlo <= m8_r[l][CW-1:0];
      dv_r[0].lane[l].quo <= '0;
      dv_r[0].lane[l].neg <= neg8_r[l];
      dv_r[0].lane[l].ovf <= (DW'(m8_r[l][MW-1:CW]) >= d8_r);
    end
  end

  for (genvar k = 0; k < NDS; k++) begin : g_div
    always_ff @(posedge clk) begin
      dv_r[k+1] <= div_step(dv_r[k]);
    end
  end

  // output stage: sign, saturation, w = 1 - u - v, zero weights when degenerate
  logic [CW-1:0]        mag [2];
  logic [CW-1:0]        lim [2];
  logic [CW-1:0]        sat [2];
  logic signed [CW-1:0] wt  [2];
  logic signed [CW+1:0] wsum;
  logic signed [CW-1:0] wsat;
  tbc_pkg::out_t        out_nxt;
  tbc_pkg::out_t        out_data_r;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag[l] = dv_r[NDS].lane[l].ovf ? '1 : dv_r[NDS].lane[l].quo;
      lim[l] = dv_r[NDS].lane[l].neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      sat[l] = (mag[l] > lim[l]) ? lim[l] : mag[l];
      wt[l]  = dv_r[NDS].lane[l].neg ? $signed(-sat[l]) : $signed(sat[l]);
    end
    wsum = ((CW+2)'(1) <<< FB) - (CW+2)'(wt[0]) - (CW+2)'(wt[1]);
    if ((wsum[CW+1:CW-1] == '0) || (wsum[CW+1:CW-1] == '1)) begin
      wsat = wsum[CW-1:0];
    end else if (wsum[CW+1]) begin
      wsat = {1'b1, {(CW-1){1'b0}}};
    end else begin
      wsat = {1'b0, {(CW-1){1'b1}}};
    end
    if (dv_r[NDS].deg) begin
      out_nxt.weight_u   = '0;
      out_nxt.weight_v   = '0;
      out_nxt.weight_w   = '0;
      out_nxt.degenerate = 1'b1;
    end else begin
      out_nxt.weight_u   = wt[0];
      out_nxt.weight_v   = wt[1];
      out_nxt.weight_w   = wsat;
      out_nxt.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_data = out_data_r;

  // checks
  localparam logic signed [CW-1:0] ONE = CW'(1) <<< FB;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##NV out_strobe)
    else $error("accepted transaction did not produce a result on time");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.degenerate) |->
      (out_data.weight_u == '0 && out_data.weight_v == '0 && out_data.weight_w == '0))
    else $error("degenerate result carries nonzero weights");

  a_w_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.degenerate && out_data.weight_u == '0 &&
     out_data.weight_v == '0) |-> (out_data.weight_w == ONE))
    else $error("w is not one when u and v are zero");

endmodule

/* tb/testbench.sv */
// testbench: self-checking regression for triangle_barycentric_coords
// exact wide-integer weight prediction, APB tolerance writes; depends on tbc_pkg
`timescale 1ns / 1ps
module testbench;
  import tbc_pkg::*;

  typedef logic signed [255:0] wide_t;

  localparam logic [ADW-1:0] ADDR_TOL    = {REG_TOL, 2'b00};
  localparam logic [ADW-1:0] ADDR_UNUSED = 3'd4;
  localparam wide_t ONE_FIX = wide_t'(1) << FB;

  // random item shapes
  typedef enum int {
    SHAPE_NEAR, SHAPE_FULL, SHAPE_COLLINEAR, SHAPE_TINY
  } shape_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_strobe;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  in_t  pending_q[$];
  out_t weights_q[$];
  logic [TW-1:0] tol_shadow = 1;
  bit   quiet = 0;
  bit   taken = 0;
  int   gap_left = 0;
  int   fails = 0;
  int   checked = 0;
  int   degen_seen = 0;
  int   sat_seen = 0;

  triangle_barycentric_coords u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // cross product of two wide vectors
  function automatic void cross_w(output wide_t r[3], input wide_t a[3], input wide_t b[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // num/den scaled by 2^FB, rounded half away from zero, saturated
  function automatic wide_t scaled_ratio(wide_t num, wide_t den);
    wide_t mag, q, lim;
    bit neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = ((mag <<< (FB + 1)) + den) / (den <<< 1);
    lim = neg ? (wide_t'(1) << (CW - 1)) : (wide_t'(1) << (CW - 1)) - 1;
    if (q > lim) q = lim;
    return neg ? -q : q;
  endfunction

  function automatic wide_t clamp_coord(wide_t x);
    wide_t hi, lo;
    hi = (wide_t'(1) << (CW - 1)) - 1;
    lo = -hi - 1;
    return x > hi ? hi : (x < lo ? lo : x);
  endfunction

  // expected weights for one query at the given tolerance
  function automatic out_t barycentric_weights(in_t x, logic [TW-1:0] tol);
    wide_t p[3], a[3], b[3], c[3], ab[3], ac[3], bp[3], cp[3], ap[3], n[3], t[3];
    wide_t den, thr, u, v, w;
    out_t r;
    p[0] = x.point_x;  p[1] = x.point_y;  p[2] = x.point_z;
    a[0] = x.vert_a_x; a[1] = x.vert_a_y; a[2] = x.vert_a_z;
    b[0] = x.vert_b_x; b[1] = x.vert_b_y; b[2] = x.vert_b_z;
    c[0] = x.vert_c_x; c[1] = x.vert_c_y; c[2] = x.vert_c_z;
    for (int i = 0; i < 3; i++) begin
      ab[i] = b[i] - a[i];
      ac[i] = c[i] - a[i];
      bp[i] = b[i] - p[i];
      cp[i] = c[i] - p[i];
      ap[i] = p[i] - a[i];
    end
    cross_w(n, ab, ac);
    den = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
    thr = (wide_t'(tol) * wide_t'(tol)) <<< (2 * FB);
    r = '0;
    if (den == 0 || den < thr) begin
      r.degenerate = 1'b1;
      return r;
    end
    cross_w(t, bp, cp);
    u = scaled_ratio(t[0] * n[0] + t[1] * n[1] + t[2] * n[2], den);
    cross_w(t, ap, ac);
    v = scaled_ratio(t[0] * n[0] + t[1] * n[1] + t[2] * n[2], den);
    w = clamp_coord(ONE_FIX - u - v);
    r.weight_u = u[CW-1:0];
    r.weight_v = v[CW-1:0];
    r.weight_w = w[CW-1:0];
    return r;
  endfunction

  function automatic logic signed [CW-1:0] rand_span(int bits);
    logic signed [CW-1:0] m;
    m = $urandom_range((1 << bits) - 1, 0);
    return $urandom_range(1, 0) ? -m : m;
  endfunction

  function automatic in_t random_query(shape_e shape);
    in_t x;
    int k;
    x = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    case (shape)
      SHAPE_NEAR: begin
        x.vert_a_x = rand_span(19); x.vert_a_y = rand_span(19); x.vert_a_z = rand_span(19);
        x.vert_b_x = rand_span(19); x.vert_b_y = rand_span(19); x.vert_b_z = rand_span(19);
        x.vert_c_x = rand_span(19); x.vert_c_y = rand_span(19); x.vert_c_z = rand_span(19);
        x.point_x = rand_span(19);  x.point_y = rand_span(19);  x.point_z = rand_span(19);
      end
      SHAPE_COLLINEAR: begin
        k = $urandom_range(6, 0) - 3;
        x.vert_a_x = rand_span(20); x.vert_a_y = rand_span(20); x.vert_a_z = rand_span(20);
        x.vert_b_x = rand_span(20); x.vert_b_y = rand_span(20); x.vert_b_z = rand_span(20);
        x.vert_c_x = x.vert_a_x + k * (x.vert_b_x - x.vert_a_x);
        x.vert_c_y = x.vert_a_y + k * (x.vert_b_y - x.vert_a_y);
        x.vert_c_z = x.vert_a_z + k * (x.vert_b_z - x.vert_a_z);
      end
      SHAPE_TINY: begin
        x.vert_a_x = rand_span(3); x.vert_a_y = rand_span(3); x.vert_a_z = rand_span(3);
        x.vert_b_x = rand_span(3); x.vert_b_y = rand_span(3); x.vert_b_z = rand_span(3);
        x.vert_c_x = rand_span(3); x.vert_c_y = rand_span(3); x.vert_c_z = rand_span(3);
      end
      default: ;
    endcase
    return x;
  endfunction

  function automatic in_t make_query(int px, int py, int pz, int ax, int ay, int az,
                                     int bx, int by, int bz, int cx, int cy, int cz);
    return {px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz};
  endfunction

  // driver: one transaction per accept, random idle bursts
  always @(negedge clk) begin
    if (rst_n && (!start || taken)) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (!quiet && $urandom_range(9, 0) == 0) begin
        start <= 1'b0;
        gap_left <= $urandom_range(13, 0);
      end else if (pending_q.size() != 0) begin
        in_data <= pending_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on accept, check each strobed result
  always @(posedge clk) begin
    taken <= rst_n && start && !busy;
    if (rst_n) begin
      if (psel && penable && pwrite && pready && paddr == ADDR_TOL)
        tol_shadow <= pwdata[TW-1:0];
      if (start && !busy) begin
        weights_q.push_back(barycentric_weights(in_data, tol_shadow));
      end
      if (out_strobe) begin
        if (weights_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          fails++;
        end else begin
          out_t e;
          e = weights_q.pop_front();
          checked++;
          if (e.degenerate) degen_seen++;
          if (e.weight_u == 32'sh7fffffff || e.weight_u == 32'sh80000000) sat_seen++;
          if (out_data.weight_u !== e.weight_u)
            $display("%0t: weight_u expected %h actual %h", $time, e.weight_u, out_data.weight_u);
          if (out_data.weight_v !== e.weight_v)
            $display("%0t: weight_v expected %h actual %h", $time, e.weight_v, out_data.weight_v);
          if (out_data.weight_w !== e.weight_w)
            $display("%0t: weight_w expected %h actual %h", $time, e.weight_w, out_data.weight_w);
          if (out_data.degenerate !== e.degenerate)
            $display("%0t: degenerate expected %b actual %b", $time, e.degenerate,
                     out_data.degenerate);
          if (out_data !== e) fails++;
        end
      end
    end
  end

  task automatic cfg_write(logic [ADW-1:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // let every queued transaction go in and every result come back
  task automatic drain;
    while (pending_q.size() != 0 || start || weights_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(9, 0);
      pending_q.push_back(random_query(r < 5 ? SHAPE_NEAR : r < 7 ? SHAPE_FULL :
                                       r < 9 ? SHAPE_COLLINEAR : SHAPE_TINY));
    end
    drain();
  endtask

  localparam int F1 = 65536;

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    cfg_write(ADDR_TOL, 32'd1);
    cfg_write(ADDR_UNUSED, 32'hffffffff);

    // directed: unit triangle at vertices, centroid, off-plane, extremes, zero normal
    pending_q.push_back(make_query(0, 0, 0, 0, 0, 0, F1, 0, 0, 0, F1, 0));
    pending_q.push_back(make_query(F1, 0, 0, 0, 0, 0, F1, 0, 0, 0, F1, 0));
    pending_q.push_back(make_query(0, F1, 0, 0, 0, 0, F1, 0, 0, 0, F1, 0));
    pending_q.push_back(make_query(21845, 21845, 0, 0, 0, 0, F1, 0, 0, 0, F1, 0));
    pending_q.push_back(make_query(F1 / 3, F1 / 3, 5 * F1, 0, 0, 0, F1, 0, 0, 0, F1, 0));
    pending_q.push_back(make_query(1, 1, -1, 0, 0, 0, 3, 0, 0, 0, 3, 0));
    pending_q.push_back(make_query(32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 1, 0, 0, 0, 1, 1));
    pending_q.push_back('1);
    pending_q.push_back('0);
    pending_q.push_back({12{32'h80000000}});
    pending_q.push_back({12{32'h7fffffff}});
    pending_q.push_back(make_query(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                   32'h80000000, 32'h7fffffff, 32'h7fffffff));
    pending_q.push_back(make_query(5, 5, 5, 0, 0, 0, F1, F1, F1, 2 * F1, 2 * F1, 2 * F1));
    pending_q.push_back(make_query(0, 0, 0, F1, 0, 0, F1, 0, 0, 0, F1, 0));
    drain();

    random_phase(400);
    cfg_write(ADDR_TOL, 32'd0);
    random_phase(300);
    cfg_write(ADDR_TOL, 32'h7fffffff);
    random_phase(60);
    cfg_write(ADDR_TOL, 32'(F1));
    random_phase(300);
    cfg_write(ADDR_TOL, $urandom);
    random_phase(240);
    cfg_write(ADDR_TOL, 32'd1);
    quiet = 1;
    random_phase(300);

    repeat (60) @(posedge clk);
    $display("checked %0d results: %0d degenerate, %0d with saturated u", checked,
             degen_seen, sat_seen);
    if (fails == 0 && weights_q.size() == 0) begin
      $display("triangle_barycentric_coords regression: pass");
    end else begin
      $display("triangle_barycentric_coords regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("timeout after %0t", $time);
    $display("triangle_barycentric_coords regression: fail");
    $finish;
  end

endmodule
